>>> hw/rtl/btiu_pkg.sv
// Shared constants, field layouts and pipeline control types of the bilinear table unit.
package btiu_pkg;

    localparam int MAX_GRID    = 16;
    localparam int IDX_W       = 4;
    localparam int HALF_W      = 3;
    localparam int BANK_DEPTH  = (MAX_GRID * MAX_GRID) / 4;
    localparam int GS_W        = 5;
    localparam int COORD_W     = 18;
    localparam int VAL_W       = 16;
    localparam int FRAC_BITS   = 14;
    localparam int SCL_W       = 23;
    localparam int WGT_W       = 2 * SCL_W;
    localparam int PRD_W       = WGT_W + VAL_W;
    localparam int ACC_W       = 64;
    localparam int OUT_SHIFT   = 28;
    localparam int Q_W         = ACC_W - OUT_SHIFT;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 24;

    localparam logic [GS_W-1:0]         GS_RESET = GS_W'(10);
    localparam logic signed [SCL_W-1:0] ONE_Q14  = SCL_W'(16384);
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (OUT_SHIFT - 1));

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_EVAL  = 1'b1
    } t_func;

    typedef struct packed {
        logic [3:0]              pad;
        logic signed [VAL_W-1:0] entry_value;
        logic [IDX_W-1:0]        entry_col;
        logic [IDX_W-1:0]        entry_row;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_x;
    } t_in_data;

    typedef struct packed {
        logic [IDX_W-1:0]        cell_col;
        logic [IDX_W-1:0]        cell_row;
        logic signed [VAL_W-1:0] interp_value;
    } t_out_data;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } t_pipe_en;

endpackage

>>> hw/rtl/btiu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module btiu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/btiu_locate.sv
// Two-stage coordinate scaling, cell index clamp and fraction for one axis.
module btiu_locate (
    input  logic                                   i_clk,
    input  btiu_pkg::t_pipe_en                     i_en,
    input  logic signed [btiu_pkg::COORD_W-1:0]    i_coord,
    input  logic [btiu_pkg::IDX_W-1:0]             i_nm1,
    input  logic [btiu_pkg::IDX_W-1:0]             i_nm2,
    output logic [btiu_pkg::IDX_W-1:0]             o_cell,
    output logic signed [btiu_pkg::SCL_W-1:0]      o_frac
);
    import btiu_pkg::*;

    localparam int IDXR_W = SCL_W - 1 - FRAC_BITS;

    logic signed [SCL_W-1:0] n_scaled;
    logic signed [SCL_W-1:0] r_scaled;
    logic [IDXR_W-1:0]       idx_raw;
    logic [IDX_W-1:0]        n_cell;
    logic signed [SCL_W-1:0] n_frac;
    logic [IDX_W-1:0]        r_cell;
    logic signed [SCL_W-1:0] r_frac;

    assign n_scaled = SCL_W'(i_coord) * SCL_W'($signed({1'b0, i_nm1}));
    assign idx_raw  = r_scaled[SCL_W-2:FRAC_BITS];

    always_comb begin
        if (r_scaled[SCL_W-1]) begin
            n_cell = '0;
        end else if (idx_raw > {{(IDXR_W-IDX_W){1'b0}}, i_nm2}) begin
            n_cell = i_nm2;
        end else begin
            n_cell = idx_raw[IDX_W-1:0];
        end
        n_frac = r_scaled
               - $signed({{(SCL_W-IDX_W-FRAC_BITS){1'b0}}, n_cell, {FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_scaled <= n_scaled;
        end
        if (i_en.s2) begin
            r_cell <= n_cell;
            r_frac <= n_frac;
        end
    end

    assign o_cell = r_cell;
    assign o_frac = r_frac;

endmodule

>>> hw/rtl/btiu_blend.sv
// Weight products, value products, accumulation, rounding and saturation stages.
module btiu_blend (
    input  logic                                   i_clk,
    input  btiu_pkg::t_pipe_en                     i_en,
    input  logic [btiu_pkg::IDX_W-1:0]             i_row,
    input  logic [btiu_pkg::IDX_W-1:0]             i_col,
    input  logic signed [btiu_pkg::SCL_W-1:0]      i_u,
    input  logic signed [btiu_pkg::SCL_W-1:0]      i_w,
    input  logic [3:0][btiu_pkg::VAL_W-1:0]        i_bank,
    output logic signed [btiu_pkg::VAL_W-1:0]      o_value,
    output logic                                   o_sat,
    output logic [btiu_pkg::IDX_W-1:0]             o_row,
    output logic [btiu_pkg::IDX_W-1:0]             o_col
);
    import btiu_pkg::*;

    logic signed [SCL_W-1:0] r3_u;
    logic signed [SCL_W-1:0] r3_w;
    logic [IDX_W-1:0]        r3_row;
    logic [IDX_W-1:0]        r3_col;

    logic signed [SCL_W-1:0] n_omu;
    logic signed [SCL_W-1:0] n_omw;
    logic signed [WGT_W-1:0] n_w00;
    logic signed [WGT_W-1:0] n_w10;
    logic signed [WGT_W-1:0] n_w01;
    logic signed [WGT_W-1:0] n_w11;
    logic [1:0]              sel00;
    logic [1:0]              sel10;
    logic [1:0]              sel01;
    logic [1:0]              sel11;

    logic signed [WGT_W-1:0] r4_w00;
    logic signed [WGT_W-1:0] r4_w10;
    logic signed [WGT_W-1:0] r4_w01;
    logic signed [WGT_W-1:0] r4_w11;
    logic signed [VAL_W-1:0] r4_v00;
    logic signed [VAL_W-1:0] r4_v10;
    logic signed [VAL_W-1:0] r4_v01;
    logic signed [VAL_W-1:0] r4_v11;
    logic [IDX_W-1:0]        r4_row;
    logic [IDX_W-1:0]        r4_col;

    logic signed [PRD_W-1:0] n_p00;
    logic signed [PRD_W-1:0] n_p10;
    logic signed [PRD_W-1:0] n_p01;
    logic signed [PRD_W-1:0] n_p11;
    logic signed [PRD_W-1:0] r5_p00;
    logic signed [PRD_W-1:0] r5_p10;
    logic signed [PRD_W-1:0] r5_p01;
    logic signed [PRD_W-1:0] r5_p11;
    logic [IDX_W-1:0]        r5_row;
    logic [IDX_W-1:0]        r5_col;

    logic signed [ACC_W-1:0] n_s0;
    logic signed [ACC_W-1:0] n_s1;
    logic signed [ACC_W-1:0] r6_s0;
    logic signed [ACC_W-1:0] r6_s1;
    logic [IDX_W-1:0]        r6_row;
    logic [IDX_W-1:0]        r6_col;

    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] n_rnd;
    logic signed [Q_W-1:0]   n_q;
    logic                    n_sat;
    logic signed [VAL_W-1:0] n_value;
    logic signed [VAL_W-1:0] r7_value;
    logic                    r7_sat;
    logic [IDX_W-1:0]        r7_row;
    logic [IDX_W-1:0]        r7_col;

    assign n_omu = ONE_Q14 - r3_u;
    assign n_omw = ONE_Q14 - r3_w;
    assign n_w00 = WGT_W'(n_omu) * WGT_W'(n_omw);
    assign n_w10 = WGT_W'(r3_u) * WGT_W'(n_omw);
    assign n_w01 = WGT_W'(n_omu) * WGT_W'(r3_w);
    assign n_w11 = WGT_W'(r3_u) * WGT_W'(r3_w);

    // bank index is {row parity, column parity}
    assign sel00 = {r3_row[0], r3_col[0]};
    assign sel10 = {~r3_row[0], r3_col[0]};
    assign sel01 = {r3_row[0], ~r3_col[0]};
    assign sel11 = {~r3_row[0], ~r3_col[0]};

    assign n_p00 = PRD_W'(r4_v00) * PRD_W'(r4_w00);
    assign n_p10 = PRD_W'(r4_v10) * PRD_W'(r4_w10);
    assign n_p01 = PRD_W'(r4_v01) * PRD_W'(r4_w01);
    assign n_p11 = PRD_W'(r4_v11) * PRD_W'(r4_w11);

    assign n_s0 = ACC_W'(r5_p00) + ACC_W'(r5_p10);
    assign n_s1 = ACC_W'(r5_p01) + ACC_W'(r5_p11);

    always_comb begin
        n_acc   = r6_s0 + r6_s1;
        n_rnd   = n_acc + HALF_LSB;
        n_q     = n_rnd[ACC_W-1:OUT_SHIFT];
        n_sat   = !((&n_q[Q_W-1:VAL_W-1]) || (~|n_q[Q_W-1:VAL_W-1]));
        n_value = n_q[VAL_W-1:0];
        if (n_sat) begin
            n_value = n_q[Q_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_u   <= i_u;
            r3_w   <= i_w;
            r3_row <= i_row;
            r3_col <= i_col;
        end
        if (i_en.s4) begin
            r4_w00 <= n_w00;
            r4_w10 <= n_w10;
            r4_w01 <= n_w01;
            r4_w11 <= n_w11;
            r4_v00 <= i_bank[sel00];
            r4_v10 <= i_bank[sel10];
            r4_v01 <= i_bank[sel01];
            r4_v11 <= i_bank[sel11];
            r4_row <= r3_row;
            r4_col <= r3_col;
        end
        if (i_en.s5) begin
            r5_p00 <= n_p00;
            r5_p10 <= n_p10;
            r5_p01 <= n_p01;
            r5_p11 <= n_p11;
            r5_row <= r4_row;
            r5_col <= r4_col;
        end
        if (i_en.s6) begin
            r6_s0  <= n_s0;
            r6_s1  <= n_s1;
            r6_row <= r5_row;
            r6_col <= r5_col;
        end
        if (i_en.s7) begin
            r7_value <= n_value;
            r7_sat   <= n_sat;
            r7_row   <= r6_row;
            r7_col   <= r6_col;
        end
    end

    assign o_value = r7_value;
    assign o_sat   = r7_sat;
    assign o_row   = r7_row;
    assign o_col   = r7_col;

endmodule

>>> hw/rtl/bilinear_table_interpolation_unit.sv
// Top level of the bilinear table unit: handshake, valid pipeline, grid banks, config.
// The slave stream carries one item per handshake; tuser[0] selects write (0) or
// evaluate (1). A write stores entry_value at (entry_row, entry_col) and gives no
// result; an evaluate gives one result item on the master stream with the blended
// value, the chosen lower cell indices and a saturation flag in tuser[0].
// An evaluate item runs from input handshake to output valid through seven register
// stages: scale, locate, grid read, weight products, value products, pair sums,
// final sum with rounding and saturation into the output register.
// Throughput is one item per cycle while m_axis_tready is high; each stage loads
// whenever it is empty or its successor loads, so bubbles close up and the block
// keeps taking items while a result waits at the output, until every stage is full.
// The grid sits in four 64-entry RAM banks split by row and column parity, so the
// four neighbors of a cell are read in the same cycle; a write is committed in the
// same stage as the reads, which keeps item order.
// Reset empties the pipeline and sets grid_size to 10; grid contents stay undefined
// until written. When m_axis_tready is low the result holds and the stages fill up.
module bilinear_table_interpolation_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [btiu_pkg::GS_W-1:0]          i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // coord_x[17:0], coord_y[35:18], entry_row[39:36], entry_col[43:40],
    // entry_value[59:44], zero pad[63:60]
    input  logic [btiu_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // func[0]
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // interp_value[15:0], cell_row[19:16], cell_col[23:20]
    output logic [btiu_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // saturated[0]
    output logic [0:0]                         m_axis_tuser
);
    import btiu_pkg::*;

    t_in_data               in_d;
    t_out_data              out_d;
    t_pipe_en               en;

    logic [GS_W-1:0]        r_grid_size;
    logic [GS_W-1:0]        grid_n;
    logic [IDX_W-1:0]       nm1;
    logic [IDX_W-1:0]       nm2;

    logic [7:1]             r_vld;
    logic [7:1]             n_vld;
    logic [7:1]             vld_in;
    logic [7:1]             rdy;

    t_func                  r1_func;
    logic [IDX_W-1:0]       r1_row;
    logic [IDX_W-1:0]       r1_col;
    logic [VAL_W-1:0]       r1_val;
    t_func                  r2_func;
    logic [IDX_W-1:0]       r2_row;
    logic [IDX_W-1:0]       r2_col;
    logic [VAL_W-1:0]       r2_val;

    logic [IDX_W-1:0]       cell_row;
    logic [IDX_W-1:0]       cell_col;
    logic signed [SCL_W-1:0] frac_u;
    logic signed [SCL_W-1:0] frac_w;

    logic [3:0]             bank_we;
    logic [3:0][VAL_W-1:0]  bank_rd;

    logic signed [VAL_W-1:0] out_value;
    logic                   out_sat;
    logic [IDX_W-1:0]       out_row;
    logic [IDX_W-1:0]       out_col;

    assign in_d = t_in_data'(s_axis_tdata);

    always_comb begin
        if (r_grid_size < GS_W'(2)) begin
            grid_n = GS_W'(2);
        end else if (r_grid_size > GS_W'(MAX_GRID)) begin
            grid_n = GS_W'(MAX_GRID);
        end else begin
            grid_n = r_grid_size;
        end
    end

    assign nm1 = IDX_W'(grid_n - GS_W'(1));
    assign nm2 = IDX_W'(grid_n - GS_W'(2));

    always_comb begin
        rdy[7] = !r_vld[7] || m_axis_tready;
        rdy[6] = !r_vld[6] || rdy[7];
        rdy[5] = !r_vld[5] || rdy[6];
        rdy[4] = !r_vld[4] || rdy[5];
        rdy[3] = !r_vld[3] || rdy[4];
        rdy[2] = !r_vld[2] || rdy[3];
        rdy[1] = !r_vld[1] || rdy[2];

        vld_in[1] = s_axis_tvalid;
        vld_in[2] = r_vld[1];
        // drop write items once they commit to the grid
        vld_in[3] = r_vld[2] && (r2_func == FUNC_EVAL);
        vld_in[4] = r_vld[3];
        vld_in[5] = r_vld[4];
        vld_in[6] = r_vld[5];
        vld_in[7] = r_vld[6];

        n_vld = (rdy & vld_in) | (~rdy & r_vld);

        en.s1 = rdy[1];
        en.s2 = rdy[2];
        en.s3 = rdy[3];
        en.s4 = rdy[4];
        en.s5 = rdy[5];
        en.s6 = rdy[6];
        en.s7 = rdy[7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_grid_size <= GS_RESET;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_grid_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r1_func <= t_func'(s_axis_tuser[0]);
            r1_row  <= in_d.entry_row;
            r1_col  <= in_d.entry_col;
            r1_val  <= in_d.entry_value;
        end
        if (en.s2) begin
            r2_func <= r1_func;
            r2_row  <= r1_row;
            r2_col  <= r1_col;
            r2_val  <= r1_val;
        end
    end

    btiu_locate u_loc_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (in_d.coord_x),
        .i_nm1   (nm1),
        .i_nm2   (nm2),
        .o_cell  (cell_row),
        .o_frac  (frac_u)
    );

    btiu_locate u_loc_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (in_d.coord_y),
        .i_nm1   (nm1),
        .i_nm2   (nm2),
        .o_cell  (cell_col),
        .o_frac  (frac_w)
    );

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PR = 1'((b >> 1) & 1);
        localparam logic PC = 1'(b & 1);

        logic [HALF_W-1:0] rd_row;
        logic [HALF_W-1:0] rd_col;

        assign rd_row = cell_row[IDX_W-1:1] + HALF_W'(cell_row[0] & ~PR);
        assign rd_col = cell_col[IDX_W-1:1] + HALF_W'(cell_col[0] & ~PC);
        assign bank_we[b] = r_vld[2] && (r2_func == FUNC_WRITE) && en.s3
                         && (r2_row[0] == PR) && (r2_col[0] == PC);

        btiu_ram #(
            .WIDTH (VAL_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr ({r2_row[IDX_W-1:1], r2_col[IDX_W-1:1]}),
            .i_wdata (r2_val),
            .i_re    (en.s3),
            .i_raddr ({rd_row, rd_col}),
            .o_rdata (bank_rd[b])
        );
    end

    btiu_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_row   (cell_row),
        .i_col   (cell_col),
        .i_u     (frac_u),
        .i_w     (frac_w),
        .i_bank  (bank_rd),
        .o_value (out_value),
        .o_sat   (out_sat),
        .o_row   (out_row),
        .o_col   (out_col)
    );

    assign out_d.interp_value = out_value;
    assign out_d.cell_row     = out_row;
    assign out_d.cell_col     = out_col;

    assign s_axis_tready   = rdy[1];
    assign m_axis_tvalid   = r_vld[7];
    assign m_axis_tdata    = out_d;
    assign m_axis_tuser[0] = out_sat;

`ifndef NO_ASSERTIONS
    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(bank_we))
        else $error("more than one grid bank written in a cycle");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] && out_sat |-> (out_value == 16'sh7fff || out_value == 16'sh8000))
        else $error("saturated result not at a range limit");

    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (out_row <= nm2 && out_col <= nm2))
        else $error("cell index beyond grid");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] && !rdy[6] |=> r_vld[6] && r_vld[7])
        else $error("item lost in a stalled stage");
`endif

endmodule

>>> tb/sv/tb_bilinear_table_interpolation_unit.sv
// Self-checking testbench for the bilinear table interpolation unit.
module tb_bilinear_table_interpolation_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import btiu_pkg::*;

    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     DRAIN_CYCLES   = 12;
    localparam int     LONG_HOLD      = 300;
    localparam int     MAX_REPORTS    = 40;
    localparam longint UNIT_Q14       = 64'sd16384;
    localparam longint VAL_MAX        = 64'sd32767;
    localparam longint VAL_MIN        = -64'sd32768;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    sat;
    } t_blend;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [GS_W-1:0]        i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // coord_x[17:0], coord_y[35:18], entry_row[39:36], entry_col[43:40],
    // entry_value[59:44], zero pad[63:60]
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    // func[0]
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // interp_value[15:0], cell_row[19:16], cell_col[23:20]
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    // saturated[0]
    logic [0:0]             m_axis_tuser;

    logic signed [VAL_W-1:0] grid_model [MAX_GRID][MAX_GRID];
    logic [GS_W-1:0]         grid_size_reg;
    t_blend                  blend_queue [$];
    int                      mismatch_count;
    bit                      tx_gaps_on;
    bit                      rx_gaps_on;
    bit                      long_hold_req;

    bilinear_table_interpolation_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_size();
        if (grid_size_reg < 2) return 2;
        if (grid_size_reg > MAX_GRID) return MAX_GRID;
        return grid_size_reg;
    endfunction

    function automatic void locate_axis(input logic signed [COORD_W-1:0] coord, input int n,
                                        output int idx, output longint frac);
        longint scaled;
        scaled = longint'(coord) * (n - 1);
        idx = (scaled < 0) ? 0 : int'(scaled >>> FRAC_BITS);
        if (idx > n - 2) idx = n - 2;
        frac = scaled - longint'(idx) * UNIT_Q14;
    endfunction

    function automatic t_blend predict_blend(input logic signed [COORD_W-1:0] x,
                                             input logic signed [COORD_W-1:0] y);
        int     n, r, c;
        longint u, w, acc, q;
        t_blend res;
        n = eff_size();
        locate_axis(x, n, r, u);
        locate_axis(y, n, c, w);
        acc = longint'(grid_model[r][c])         * ((UNIT_Q14 - u) * (UNIT_Q14 - w))
            + longint'(grid_model[r + 1][c])     * (u * (UNIT_Q14 - w))
            + longint'(grid_model[r][c + 1])     * ((UNIT_Q14 - u) * w)
            + longint'(grid_model[r + 1][c + 1]) * (u * w);
        q = (acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        res.sat = 1'b0;
        if (q > VAL_MAX) begin
            q = VAL_MAX;
            res.sat = 1'b1;
        end else if (q < VAL_MIN) begin
            q = VAL_MIN;
            res.sat = 1'b1;
        end
        res.value = q[VAL_W-1:0];
        res.row   = r[IDX_W-1:0];
        res.col   = c[IDX_W-1:0];
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int sel, n;
        sel = $urandom_range(0, 9);
        n = eff_size();
        if (sel <= 5) return COORD_W'($urandom_range(0, 16384));
        if (sel <= 7) return COORD_W'(int'($urandom_range(0, 32768)) - 8192);
        if (sel == 8) return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, n - 1)) * 16384 / (n - 1)
                        + int'($urandom_range(0, 2)) - 1);
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'sh7fff;
        if (r == 1) return 16'sh8000;
        return VAL_W'($urandom);
    endfunction

    task automatic send_item(input t_func f, input t_in_data d);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        if (f == FUNC_WRITE)
            grid_model[d.entry_row][d.entry_col] = d.entry_value;
        else
            blend_queue.push_back(predict_blend(d.coord_x, d.coord_y));
    endtask

    task automatic send_write(input int row, input int col, input logic signed [VAL_W-1:0] v);
        t_in_data d;
        d             = t_in_data'({$urandom, $urandom});
        d.pad         = '0;
        d.entry_row   = IDX_W'(row);
        d.entry_col   = IDX_W'(col);
        d.entry_value = v;
        send_item(FUNC_WRITE, d);
    endtask

    task automatic send_eval(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        t_in_data d;
        d         = t_in_data'({$urandom, $urandom});
        d.pad     = '0;
        d.coord_x = x;
        d.coord_y = y;
        send_item(FUNC_EVAL, d);
    endtask

    task automatic send_random(input int count, input int write_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < write_pct)
                send_write($urandom_range(0, MAX_GRID - 1), $urandom_range(0, MAX_GRID - 1),
                           rand_value());
            else
                send_eval(rand_coord(), rand_coord());
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (blend_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid_size(input logic [GS_W-1:0] v);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        grid_size_reg = v;
    endtask

    task automatic test_grid_load();
        for (int r = 0; r < MAX_GRID; r++)
            for (int c = 0; c < MAX_GRID; c++)
                send_write(r, c, rand_value());
    endtask

    task automatic test_edge_cases();
        send_write(0, 0, 16'sh7fff);
        send_write(1, 0, 16'sh7fff);
        send_write(0, 1, 16'sh8000);
        send_write(1, 1, 16'sh8000);
        send_write(15, 15, 16'sh8000);
        send_eval(18'sd0, 18'sd0);
        send_eval(-18'sd131072, -18'sd131072);
        send_eval(18'sd131071, 18'sd131071);
        send_eval(-18'sd131072, 18'sd131071);
        send_eval(18'sd131071, -18'sd131072);
        send_eval(18'sd16384, 18'sd16384);
        send_eval(-18'sd1, -18'sd1);
        send_eval(18'sd8192, 18'sd8192);
        send_eval(18'sd1820, 18'sd1821);
        send_eval(18'sd16383, 18'sd0);
    endtask

    task automatic test_grid_sizes();
        int sizes [9] = '{2, 16, 0, 1, 17, 31, 3, 7, 15};
        foreach (sizes[i]) begin
            set_grid_size(GS_W'(sizes[i]));
            tx_gaps_on = (i % 3) != 0;
            rx_gaps_on = (i % 4) != 1;
            send_eval(18'sd0, 18'sd16384);
            send_eval(18'sd16384, 18'sd0);
            send_random(38, 10);
        end
    endtask

    task automatic test_backpressure();
        set_grid_size(GS_W'($urandom_range(2, MAX_GRID)));
        tx_gaps_on    = 1'b0;
        rx_gaps_on    = 1'b1;
        long_hold_req = 1'b1;
        send_random(80, 0);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_mix();
        repeat (5) begin
            set_grid_size(GS_W'($urandom_range(0, 31)));
            tx_gaps_on = $urandom_range(0, 3) != 0;
            rx_gaps_on = $urandom_range(0, 3) != 0;
            send_random(110, 20);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_data got;
        t_blend    want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_out_data'(m_axis_tdata);
            if (blend_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected item, expected none, got value=%0d row=%0d col=%0d sat=%0b",
                             $time, got.interp_value, got.cell_row, got.cell_col, m_axis_tuser[0]);
            end else begin
                want = blend_queue.pop_front();
                if (got.interp_value !== want.value || got.cell_row !== want.row ||
                    got.cell_col !== want.col || m_axis_tuser[0] !== want.sat) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch, expected value=%0d row=%0d col=%0d sat=%0b, %s%0d %s%0d %s%0d %s%0b",
                                 $time, want.value, want.row, want.col, want.sat,
                                 "got value=", got.interp_value, "row=", got.cell_row,
                                 "col=", got.cell_col, "sat=", m_axis_tuser[0]);
                end
            end
        end
    end

    // receiver
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = rx_gaps_on ? pick_gap() : 0;
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // watchdog
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        mismatch_count = 0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        long_hold_req  = 1'b0;
        grid_size_reg  = GS_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_grid_load();
        test_edge_cases();
        test_grid_sizes();
        test_backpressure();
        test_random_mix();
        wait_drain();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
